// File: hw/rtl/psf_pkg.sv
// ----------------------------------------------------------------------------
// psf_pkg
// Shared types and constants of the perspective starfield step block.
// ----------------------------------------------------------------------------
package psf_pkg;

	localparam int COORD_W = 20;
	localparam int DEPTH_W = 17;
	localparam int PIX_W   = 12;
	localparam int COL_W   = 2;
	localparam int DIV_W   = 29;
	localparam int DVR_W   = 16;
	localparam int RAND_W  = 15;
	localparam int SPD_W   = 11;

	localparam logic signed [DEPTH_W-1:0] SPAWN_DEPTH = 17'sd45512;
	localparam logic signed [DEPTH_W-1:0] DEAD_DEPTH  = -17'sd1;
	localparam logic [15:0] FAR_DEPTH = 16'd45000;
	localparam logic [31:0] LCG_MUL   = 32'h0003_43fd;
	localparam logic [31:0] LCG_INC   = 32'h0026_9ec3;
	localparam logic [5:0]  COLOR_MASK = 6'd63;

	localparam logic [COL_W-1:0] COL_WHITE = 2'd0;
	localparam logic [COL_W-1:0] COL_CYAN  = 2'd1;
	localparam logic [COL_W-1:0] COL_RED   = 2'd2;

	localparam logic PIX_ERASE = 1'b0;
	localparam logic PIX_DRAW  = 1'b1;

	localparam logic [2:0] CFG_LEFT   = 3'd0;
	localparam logic [2:0] CFG_RIGHT  = 3'd1;
	localparam logic [2:0] CFG_BOTTOM = 3'd2;
	localparam logic [2:0] CFG_TOP    = 3'd3;
	localparam logic [2:0] CFG_SPEED  = 3'd4;
	localparam logic [2:0] CFG_SEED   = 3'd5;

	// Datapath operations issued by the controller.
	localparam logic [4:0] OP_NONE      = 5'd0;
	localparam logic [4:0] OP_CLR       = 5'd1;
	localparam logic [4:0] OP_TAKE      = 5'd2;
	localparam logic [4:0] OP_LOAD      = 5'd3;
	localparam logic [4:0] OP_SUB       = 5'd4;
	localparam logic [4:0] OP_DIV_START = 5'd5;
	localparam logic [4:0] OP_DIV_STORE = 5'd6;
	localparam logic [4:0] OP_BND       = 5'd7;
	localparam logic [4:0] OP_SP_RAND   = 5'd8;
	localparam logic [4:0] OP_SP_SIZE   = 5'd9;
	localparam logic [4:0] OP_SP_MUL    = 5'd10;
	localparam logic [4:0] OP_SP_COORD  = 5'd11;
	localparam logic [4:0] OP_COL_RAND  = 5'd12;
	localparam logic [4:0] OP_COL_WHITE = 5'd13;
	localparam logic [4:0] OP_COL_PICK  = 5'd14;
	localparam logic [4:0] OP_WB        = 5'd15;
	localparam logic [4:0] OP_EMIT_E    = 5'd16;
	localparam logic [4:0] OP_EMIT_D    = 5'd17;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [DEPTH_W-1:0] depth;
		logic [COL_W-1:0]          color;
		logic [PIX_W-1:0]          ox;
		logic [PIX_W-1:0]          oy;
		logic                      ov;
	} star_rec_t;

	typedef struct packed {
		logic [4:0] op;
		logic       sel;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic in_range;
		logic live;
		logic alive;
		logic div_done;
		logic spawn;
		logic col_white;
		logic erase;
		logic draw;
		logic out_free;
	} stat_t;

endpackage

// File: hw/rtl/perspective_starfield_step.sv
// ----------------------------------------------------------------------------
// perspective_starfield_step
// Moves one star of a perspective starfield per input word.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries a slot index; slot zero also
// opens a frame and tops up the spawn budget. Output channel
// (out_valid/out_ready) carries pixel words: an erase of the old pixel,
// a draw of the new one, or both, with last_of_slot on the final word.
// A slot that is out of range, dead with no budget, or never drawn may give
// no word at all.
// One word is handled at a time. A live star keeps in_ready low after its
// word is taken while it waits on the two passes of the shared divider,
// and a respawn adds the spawn steps; a dead slot with no budget and a star
// that dies on its depth step skip the divider.
// After reset the star table is swept once, one slot per cycle, and in_ready
// stays low until the sweep ends; configuration writes are taken throughout.
// A result waits in the output register while the receiver stalls. Whenever
// a new result is due while that register is still full, the sequencer holds
// until the receiver takes the waiting word, which lengthens the item.
// ----------------------------------------------------------------------------
module perspective_starfield_step #(
	parameter int NUM_STARS       = 256,
	parameter int SPAWN_PER_FRAME = 3
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [7:0]                slot_index,
	input  logic                      cfg_we,
	input  logic [2:0]                cfg_index,
	input  logic [31:0]               cfg_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      pixel_op,
	output logic [psf_pkg::PIX_W-1:0] pixel_x,
	output logic [psf_pkg::PIX_W-1:0] pixel_y,
	output logic [psf_pkg::COL_W-1:0] pixel_color,
	output logic                      last_of_slot
);
	import psf_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// The sequencer decides each step; the datapath holds all data state.
	psf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	psf_dp #(
		.NUM_STARS       (NUM_STARS),
		.SPAWN_PER_FRAME (SPAWN_PER_FRAME)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.slot_index   (slot_index),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.pixel_op     (pixel_op),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.pixel_color  (pixel_color),
		.last_of_slot (last_of_slot)
	);

endmodule

// File: hw/rtl/psf_div.sv
// ----------------------------------------------------------------------------
// psf_div
// Iterative signed divider, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
module psf_div (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic signed [psf_pkg::DIV_W-1:0]       dividend,
	input  logic [psf_pkg::DVR_W-1:0]              divisor,
	output logic                                   done,
	output logic signed [psf_pkg::DIV_W-1:0]       quotient
);
	import psf_pkg::*;

	logic [DIV_W-1:0] quo_q;
	logic [DVR_W-1:0] rem_q;
	logic [DVR_W-1:0] dvr_q;
	logic [4:0]       cnt_q;
	logic             busy_q;
	logic             neg_q;
	logic             done_q;
	logic [DVR_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, dvr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DIV_W-1];
			quo_q <= dividend[DIV_W-1] ? DIV_W'(-dividend) : dividend;
			rem_q <= '0;
			dvr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DVR_W'(trial - {1'b0, dvr_q}) : trial[DVR_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

// File: hw/rtl/psf_ctrl.sv
// ----------------------------------------------------------------------------
// psf_ctrl
// Sequencer that steps the datapath through one slot update.
// ----------------------------------------------------------------------------
module psf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  psf_pkg::stat_t stat,
	output psf_pkg::cmd_t  cmd
);
	import psf_pkg::*;

	localparam logic [4:0] S_CLR   = 5'd0;
	localparam logic [4:0] S_IDLE  = 5'd1;
	localparam logic [4:0] S_RD    = 5'd2;
	localparam logic [4:0] S_LOAD  = 5'd3;
	localparam logic [4:0] S_SUB   = 5'd4;
	localparam logic [4:0] S_ALIVE = 5'd5;
	localparam logic [4:0] S_DIVX  = 5'd6;
	localparam logic [4:0] S_WX    = 5'd7;
	localparam logic [4:0] S_DIVY  = 5'd8;
	localparam logic [4:0] S_WY    = 5'd9;
	localparam logic [4:0] S_BND   = 5'd10;
	localparam logic [4:0] S_SPCHK = 5'd11;
	localparam logic [4:0] S_SP1   = 5'd12;
	localparam logic [4:0] S_SP2   = 5'd13;
	localparam logic [4:0] S_SP3   = 5'd14;
	localparam logic [4:0] S_SP4   = 5'd15;
	localparam logic [4:0] S_COL1  = 5'd16;
	localparam logic [4:0] S_COL2  = 5'd17;
	localparam logic [4:0] S_WB    = 5'd18;
	localparam logic [4:0] S_EMITE = 5'd19;
	localparam logic [4:0] S_EMITD = 5'd20;

	logic [4:0] state_q, state_d;
	logic       sel_q, sel_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		sel_d   = sel_q;
		cmd.op  = OP_NONE;
		cmd.sel = sel_q;
		unique case (state_q)
			S_CLR: begin
				if (stat.clr_done) state_d = S_IDLE;
				else cmd.op = OP_CLR;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_TAKE;
					state_d = S_RD;
				end
			end
			S_RD: state_d = stat.in_range ? S_LOAD : S_IDLE;
			S_LOAD: begin
				cmd.op  = OP_LOAD;
				state_d = stat.live ? S_SUB : S_SPCHK;
			end
			S_SUB: begin
				cmd.op  = OP_SUB;
				state_d = S_ALIVE;
			end
			S_ALIVE: state_d = stat.alive ? S_DIVX : S_SPCHK;
			S_DIVX: begin
				cmd.op  = OP_DIV_START;
				cmd.sel = 1'b0;
				state_d = S_WX;
			end
			S_WX: begin
				if (stat.div_done) begin
					cmd.op  = OP_DIV_STORE;
					cmd.sel = 1'b0;
					state_d = S_DIVY;
				end
			end
			S_DIVY: begin
				cmd.op  = OP_DIV_START;
				cmd.sel = 1'b1;
				state_d = S_WY;
			end
			S_WY: begin
				if (stat.div_done) begin
					cmd.op  = OP_DIV_STORE;
					cmd.sel = 1'b1;
					state_d = S_BND;
				end
			end
			S_BND: begin
				cmd.op  = OP_BND;
				state_d = S_SPCHK;
			end
			S_SPCHK: begin
				sel_d   = 1'b0;
				state_d = stat.spawn ? S_SP1 : S_WB;
			end
			S_SP1: begin
				cmd.op  = OP_SP_RAND;
				state_d = S_SP2;
			end
			S_SP2: begin
				cmd.op  = OP_SP_SIZE;
				state_d = S_SP3;
			end
			S_SP3: begin
				cmd.op  = OP_SP_MUL;
				state_d = S_SP4;
			end
			S_SP4: begin
				cmd.op = OP_SP_COORD;
				if (sel_q) begin
					state_d = S_COL1;
				end else begin
					sel_d   = 1'b1;
					state_d = S_SP1;
				end
			end
			S_COL1: begin
				cmd.op  = OP_COL_RAND;
				state_d = S_COL2;
			end
			S_COL2: begin
				cmd.op  = stat.col_white ? OP_COL_WHITE : OP_COL_PICK;
				state_d = S_WB;
			end
			S_WB: begin
				cmd.op  = OP_WB;
				state_d = S_EMITE;
			end
			S_EMITE: begin
				if (!stat.erase) begin
					state_d = S_EMITD;
				end else if (stat.out_free) begin
					cmd.op  = OP_EMIT_E;
					state_d = S_EMITD;
				end
			end
			S_EMITD: begin
				if (!stat.draw) begin
					state_d = S_IDLE;
				end else if (stat.out_free) begin
					cmd.op  = OP_EMIT_D;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			sel_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
		end
	end

endmodule

// File: hw/rtl/psf_dp.sv
// ----------------------------------------------------------------------------
// psf_dp
// Datapath: star table, settings, generator, divider and result register.
// ----------------------------------------------------------------------------
module psf_dp #(
	parameter int NUM_STARS       = 256,
	parameter int SPAWN_PER_FRAME = 3
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  psf_pkg::cmd_t                  cmd,
	output psf_pkg::stat_t                 stat,
	input  logic [7:0]                     slot_index,
	input  logic                           cfg_we,
	input  logic [2:0]                     cfg_index,
	input  logic [31:0]                    cfg_data,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic                           pixel_op,
	output logic [psf_pkg::PIX_W-1:0]      pixel_x,
	output logic [psf_pkg::PIX_W-1:0]      pixel_y,
	output logic [psf_pkg::COL_W-1:0]      pixel_color,
	output logic                           last_of_slot
);
	import psf_pkg::*;

	localparam int AW = $clog2(NUM_STARS);
	localparam logic [10:0] NS = 11'(NUM_STARS);

	// Settings and global state.
	logic [PIX_W-1:0] left_q, right_q, bottom_q, top_q;
	logic [SPD_W-1:0] speed_q;
	logic [31:0]      lcg_q, lcg_nxt;
	logic [RAND_W-1:0] rand_q;
	logic [7:0]       budget_q;
	logic [8:0]       bsum;

	// Table and working copy of one record.
	star_rec_t mem [NUM_STARS];
	star_rec_t rd_q, wd_rec;
	logic [AW-1:0] clr_cnt_q, addr;
	logic          clr_done_q;
	logic [7:0]    slot_q;
	logic          mem_we;

	logic signed [COORD_W-1:0] wx_q, wy_q;
	logic signed [DEPTH_W-1:0] wd_q;
	logic [COL_W-1:0]          wc_q, ec_q;
	logic [PIX_W-1:0]          wox_q, woy_q, ex_q, ey_q;
	logic                      wov_q, erase_q, draw_q;
	logic signed [DIV_W-1:0]   qx_q, qy_q, quot;
	logic                      div_done;

	// Projection.
	logic [PIX_W-1:0]  xc, yc;
	logic signed [29:0] px, py;
	logic              off;

	// Spawn arithmetic.
	logic [PIX_W-1:0]   hi, lo;
	logic signed [12:0] diff;
	logic signed [13:0] half;
	logic signed [29:0] prod_q, prod, adj;
	logic signed [COORD_W-1:0] size_q, coord;
	logic signed [35:0] mp_q;

	assign lcg_nxt = lcg_q * LCG_MUL + LCG_INC;
	assign bsum    = {1'b0, budget_q} + 9'(SPAWN_PER_FRAME);
	assign addr    = AW'({3'b000, slot_q});

	assign xc = PIX_W'(({1'b0, right_q} + {1'b0, left_q}) >> 1);
	assign yc = PIX_W'(({1'b0, top_q} + {1'b0, bottom_q}) >> 1);
	assign px = $signed({18'd0, xc}) + 30'(qx_q);
	assign py = $signed({18'd0, yc}) + 30'(qy_q);
	assign off = (px > $signed({18'd0, right_q})) || (px < $signed({18'd0, left_q})) ||
		(py > $signed({18'd0, top_q})) || (py < $signed({18'd0, bottom_q}));

	assign hi    = cmd.sel ? top_q : right_q;
	assign lo    = cmd.sel ? bottom_q : left_q;
	assign diff  = $signed({1'b0, hi}) - $signed({1'b0, lo});
	assign half  = 14'(diff >>> 1) + 14'sd1;
	assign prod  = half * $signed({1'b0, FAR_DEPTH});
	assign adj   = prod_q + (prod_q < 30'sd0 ? 30'sd511 : 30'sd0);
	assign coord = COORD_W'(mp_q >>> 14) - size_q;

	psf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.op == OP_DIV_START),
		.dividend ({cmd.sel ? wy_q : wx_q, 9'd0}),
		.divisor  (DVR_W'(wd_q)),
		.done     (div_done),
		.quotient (quot)
	);

	// Table port: clearing pass after reset, write-back per item.
	always_comb begin
		wd_rec = '0;
		wd_rec.depth = DEAD_DEPTH;
		if (cmd.op == OP_WB) begin
			wd_rec.x     = wx_q;
			wd_rec.y     = wy_q;
			wd_rec.depth = wd_q;
			wd_rec.color = wc_q;
			wd_rec.ox    = wox_q;
			wd_rec.oy    = woy_q;
			wd_rec.ov    = wov_q;
		end
	end
	assign mem_we = (cmd.op == OP_CLR) || (cmd.op == OP_WB);

	always_ff @(posedge clk) begin
		if (mem_we) mem[(cmd.op == OP_CLR) ? clr_cnt_q : addr] <= wd_rec;
		rd_q <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q  <= '0;
			clr_done_q <= 1'b0;
		end else if (cmd.op == OP_CLR) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == AW'(NUM_STARS - 1)) clr_done_q <= 1'b1;
		end
	end

	// Settings, generator and spawn budget.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= 12'd0;
			right_q  <= 12'd639;
			bottom_q <= 12'd0;
			top_q    <= 12'd479;
			speed_q  <= 11'd900;
			lcg_q    <= 32'd1;
			budget_q <= '0;
		end else begin
			if (cmd.op == OP_TAKE && slot_index == 8'd0)
				budget_q <= bsum[8] ? 8'hff : bsum[7:0];
			if (cmd.op == OP_SP_RAND && !cmd.sel)
				budget_q <= budget_q - 8'd1;
			if (cmd.op == OP_SP_RAND || cmd.op == OP_COL_RAND || cmd.op == OP_COL_PICK)
				lcg_q <= lcg_nxt;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_LEFT:   left_q   <= cfg_data[PIX_W-1:0];
					CFG_RIGHT:  right_q  <= cfg_data[PIX_W-1:0];
					CFG_BOTTOM: bottom_q <= cfg_data[PIX_W-1:0];
					CFG_TOP:    top_q    <= cfg_data[PIX_W-1:0];
					CFG_SPEED:  speed_q  <= cfg_data[SPD_W-1:0];
					CFG_SEED:   lcg_q    <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Working record and arithmetic steps.
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_TAKE: slot_q <= slot_index;
			OP_LOAD: begin
				wx_q  <= rd_q.x;
				wy_q  <= rd_q.y;
				wd_q  <= rd_q.depth;
				wc_q  <= rd_q.color;
				wox_q <= rd_q.ox;
				woy_q <= rd_q.oy;
				ex_q  <= rd_q.ox;
				ey_q  <= rd_q.oy;
				ec_q  <= rd_q.color;
				if (stat.live) wov_q <= 1'b0;
				else wov_q <= rd_q.ov;
			end
			OP_SUB: wd_q <= wd_q - $signed({6'd0, speed_q});
			OP_DIV_STORE: begin
				if (cmd.sel) qy_q <= quot;
				else qx_q <= quot;
			end
			OP_BND: begin
				if (off) begin
					wd_q <= DEAD_DEPTH;
				end else begin
					wox_q <= px[PIX_W-1:0];
					woy_q <= py[PIX_W-1:0];
					wov_q <= 1'b1;
				end
			end
			OP_SP_RAND: begin
				rand_q <= lcg_nxt[30:16];
				prod_q <= prod;
				if (!cmd.sel) begin
					wd_q  <= SPAWN_DEPTH;
					wov_q <= 1'b0;
				end
			end
			OP_SP_SIZE: size_q <= COORD_W'(adj >>> 9);
			OP_SP_MUL:  mp_q <= size_q * $signed({1'b0, rand_q});
			OP_SP_COORD: begin
				if (cmd.sel) wy_q <= coord;
				else wx_q <= coord;
			end
			OP_COL_RAND:  rand_q <= lcg_nxt[30:16];
			OP_COL_WHITE: wc_q <= COL_WHITE;
			OP_COL_PICK:  wc_q <= lcg_nxt[16] ? COL_CYAN : COL_RED;
			default: ;
		endcase
	end

	// Erase and draw decisions.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			erase_q <= 1'b0;
			draw_q  <= 1'b0;
		end else if (cmd.op == OP_LOAD) begin
			erase_q <= stat.live && rd_q.ov;
			draw_q  <= 1'b0;
		end else if (cmd.op == OP_BND) begin
			draw_q <= !off;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.op == OP_EMIT_E || cmd.op == OP_EMIT_D) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_EMIT_E) begin
			pixel_op     <= PIX_ERASE;
			pixel_x      <= ex_q;
			pixel_y      <= ey_q;
			pixel_color  <= ec_q;
			last_of_slot <= !draw_q;
		end else if (cmd.op == OP_EMIT_D) begin
			pixel_op     <= PIX_DRAW;
			pixel_x      <= wox_q;
			pixel_y      <= woy_q;
			pixel_color  <= wc_q;
			last_of_slot <= 1'b1;
		end
	end

	assign stat.clr_done  = clr_done_q;
	assign stat.in_range  = {3'b000, slot_q} < NS;
	assign stat.live      = rd_q.depth > 17'sd0;
	assign stat.alive     = wd_q > 17'sd0;
	assign stat.div_done  = div_done;
	assign stat.spawn     = (budget_q != 8'd0) && !(wd_q > 17'sd0);
	assign stat.col_white = (rand_q[5:0] & COLOR_MASK) != 6'd0;
	assign stat.erase     = erase_q;
	assign stat.draw      = draw_q;
	assign stat.out_free  = !out_valid || out_ready;

endmodule

// File: hw/rtl/psf_chk.sv
// ----------------------------------------------------------------------------
// psf_chk
// Port-level checks on the starfield step block, bound to the top level.
// ----------------------------------------------------------------------------
module psf_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        pixel_op,
	input logic [11:0] pixel_x,
	input logic [1:0]  pixel_color,
	input logic        last_of_slot
);
	import psf_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_x))
		else $error("stalled word dropped or changed");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word taken while one is in work");

	a_colour: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pixel_color != 2'd3)
		else $error("colour code out of range");

	a_erase_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_slot |-> pixel_op == PIX_ERASE)
		else $error("draw word not marked last");

endmodule

bind perspective_starfield_step psf_chk u_psf_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.pixel_op     (pixel_op),
	.pixel_x      (pixel_x),
	.pixel_color  (pixel_color),
	.last_of_slot (last_of_slot)
);

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the perspective starfield step block: frames of
// slot words under several screen, speed and seed settings, random idling on
// both channels, and a scoreboard that predicts every pixel word.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
	import psf_pkg::*;

	localparam int TABLE_SIZE = 256;
	localparam int SPAWN_STEP = 3;
	localparam int VIEW_DIST  = 512;
	localparam int FAR_DIST   = 45000;
	localparam int BUDGET_MAX = 255;

	// One pixel word as it leaves the block.
	typedef struct {
		logic             op;
		logic [PIX_W-1:0] x;
		logic [PIX_W-1:0] y;
		logic [COL_W-1:0] color;
		logic             last;
	} pixel_word_t;

	// The scoreboard keeps its own copy of the star table and registers, and
	// turns each accepted slot word into the pixel words it should cause.
	class starfield_scoreboard;
		int          scr_left, scr_right, scr_bottom, scr_top, speed;
		logic [31:0] lcg;
		int          pos_x[TABLE_SIZE], pos_y[TABLE_SIZE], depth[TABLE_SIZE];
		logic [1:0]  hue[TABLE_SIZE];
		int          last_x[TABLE_SIZE], last_y[TABLE_SIZE];
		bit          shown[TABLE_SIZE];
		int          budget;
		pixel_word_t pixels_due[$];
		int          errors;

		function new();
			scr_left = 0; scr_right = 639; scr_bottom = 0; scr_top = 479;
			speed = 900; lcg = 32'd1; budget = 0; errors = 0;
			for (int i = 0; i < TABLE_SIZE; i++) begin
				depth[i] = -1; shown[i] = 0;
				pos_x[i] = 0; pos_y[i] = 0; hue[i] = COL_WHITE;
				last_x[i] = 0; last_y[i] = 0;
			end
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] v);
			case (idx)
				CFG_LEFT:   scr_left = int'(v[11:0]);
				CFG_RIGHT:  scr_right = int'(v[11:0]);
				CFG_BOTTOM: scr_bottom = int'(v[11:0]);
				CFG_TOP:    scr_top = int'(v[11:0]);
				CFG_SPEED:  speed = int'(v[10:0]);
				CFG_SEED:   lcg = v;
				default: ;
			endcase
		endfunction

		function logic [14:0] next_draw();
			lcg = lcg * LCG_MUL + LCG_INC;
			return lcg[30:16];
		endfunction

		// Floor halving is an arithmetic shift; the size division truncates.
		function int spawn_coord(int hi, int lo);
			longint half, size, r;
			half = ((longint'(hi) - lo) >>> 1) + 1;
			size = (half * FAR_DIST) / VIEW_DIST;
			r = longint'(next_draw());
			return int'(((size * r) >>> 14) - size);
		endfunction

		function void push(logic op, int x, int y, logic [1:0] c);
			pixel_word_t w;
			w.op = op; w.x = x[11:0]; w.y = y[11:0]; w.color = c; w.last = 1'b0;
			pixels_due.push_back(w);
		endfunction

		function void note_slot(logic [7:0] s);
			int     n0;
			longint z, xc, yc, px, py;
			n0 = pixels_due.size();
			if (s == 0)
				budget = (budget + SPAWN_STEP > BUDGET_MAX) ? BUDGET_MAX : budget + SPAWN_STEP;
			if (s >= TABLE_SIZE)
				return;
			if (depth[s] > 0) begin
				if (shown[s]) begin
					push(PIX_ERASE, last_x[s], last_y[s], hue[s]);
					shown[s] = 0;
				end
				depth[s] -= speed;
				if (depth[s] > 0) begin
					z = depth[s];
					xc = (longint'(scr_right) + scr_left) >>> 1;
					yc = (longint'(scr_top) + scr_bottom) >>> 1;
					px = xc + (longint'(VIEW_DIST) * pos_x[s]) / z;
					py = yc + (longint'(VIEW_DIST) * pos_y[s]) / z;
					if (px > scr_right || px < scr_left || py > scr_top || py < scr_bottom) begin
						depth[s] = -1;
					end else begin
						last_x[s] = int'(px); last_y[s] = int'(py); shown[s] = 1;
						push(PIX_DRAW, last_x[s], last_y[s], hue[s]);
					end
				end
			end
			if (budget != 0 && depth[s] <= 0) begin
				budget--;
				depth[s] = FAR_DIST + VIEW_DIST;
				pos_x[s] = spawn_coord(scr_right, scr_left);
				pos_y[s] = spawn_coord(scr_top, scr_bottom);
				if ((next_draw() & 15'd63) != 0) hue[s] = COL_WHITE;
				else hue[s] = next_draw() & 15'd1 ? COL_CYAN : COL_RED;
				shown[s] = 0;
			end
			if (pixels_due.size() > n0)
				pixels_due[pixels_due.size() - 1].last = 1'b1;
		endfunction

		task report(string msg);
			$display("tb: mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_pixel(pixel_word_t got);
			pixel_word_t w;
			if (pixels_due.size() == 0) begin
				report("pixel word with none expected");
				return;
			end
			w = pixels_due.pop_front();
			if (got.op !== w.op) report($sformatf("op %0b, want %0b", got.op, w.op));
			if (got.x !== w.x) report($sformatf("x %0d, want %0d", got.x, w.x));
			if (got.y !== w.y) report($sformatf("y %0d, want %0d", got.y, w.y));
			if (got.color !== w.color)
				report($sformatf("color %0d, want %0d", got.color, w.color));
			if (got.last !== w.last)
				report($sformatf("last %0b, want %0b", got.last, w.last));
		endtask
	endclass

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	logic [7:0]       slot_index;
	logic             cfg_we;
	logic [2:0]       cfg_index;
	logic [31:0]      cfg_data;
	logic             out_valid;
	logic             out_ready;
	logic             pixel_op;
	logic [PIX_W-1:0] pixel_x;
	logic [PIX_W-1:0] pixel_y;
	logic [COL_W-1:0] pixel_color;
	logic             last_of_slot;

	starfield_scoreboard sb = new();

	// Set by the stimulus to ask the receiver for one long hold-off.
	bit hold_req  = 0;
	// Cleared to run the receiver flat out for a stretch.
	bit sink_busy = 1;

	perspective_starfield_step dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .slot_index(slot_index),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_ready(out_ready),
		.pixel_op(pixel_op), .pixel_x(pixel_x), .pixel_y(pixel_y),
		.pixel_color(pixel_color), .last_of_slot(last_of_slot)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Handshakes are sampled at the edge, before the block's own updates land.
	always @(posedge clk) begin
		pixel_word_t got;
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_slot(slot_index);
			if (out_valid && out_ready) begin
				got.op = pixel_op; got.x = pixel_x; got.y = pixel_y;
				got.color = pixel_color; got.last = last_of_slot;
				sb.check_pixel(got);
			end
		end
	end

	// Mostly short gaps, now and then a long one.
	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Receiver: random ready pattern, with one long counted hold-off on request.
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (3000) @(posedge clk);
				hold_req = 0;
			end else if (!sink_busy) begin
				out_ready <= 1'b1;
				@(posedge clk);
			end else begin
				out_ready <= ($urandom_range(0, 99) < 60);
				repeat (pick_gap() + 1) @(posedge clk);
			end
		end
	end

	// Offer one slot word and hold it until taken; valid stays up if no gap.
	task send_slot(logic [7:0] s, int gap);
		in_valid <= 1'b1;
		slot_index <= s;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Registers change only once the block has drained; a slot that gave no
	// word may still be busy, so wait out a full slot's worth beyond that.
	task wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pixels_due.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	// The write enable stays up across a run of writes; the caller drops it.
	task write_reg(logic [2:0] idx, logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		sb.set_reg(idx, v);
	endtask

	task set_screen(int l, int r, int b, int t, int spd, logic [31:0] seed);
		write_reg(CFG_LEFT, l);
		write_reg(CFG_RIGHT, r);
		write_reg(CFG_BOTTOM, b);
		write_reg(CFG_TOP, t);
		write_reg(CFG_SPEED, spd);
		write_reg(CFG_SEED, seed);
		cfg_we <= 1'b0;
	endtask

	// Frames: a slot-zero word, then a handful of slots from a small group so
	// that stars are revisited and live out their flight. Some noise mixed in.
	task run_frames(int count);
		int sent, k;
		sent = 0;
		while (sent < count) begin
			send_slot(8'd0, pick_gap());
			sent++;
			k = $urandom_range(2, 12);
			for (int i = 0; i < k && sent < count; i++) begin
				if ($urandom_range(0, 9) == 0) send_slot(8'($urandom_range(0, 255)), pick_gap());
				else send_slot(8'($urandom_range(1, 20)), pick_gap());
				sent++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		slot_index = 8'd0;
		cfg_we = 1'b0;
		cfg_index = CFG_LEFT;
		cfg_data = 32'd0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: slots with no budget, field extremes, then spawn and fly.
		send_slot(8'd255, 0);
		send_slot(8'd128, 1);
		send_slot(8'd0, 0);
		send_slot(8'd1, 0);
		send_slot(8'd255, 0);
		send_slot(8'd0, 2);
		for (int i = 0; i < 14; i++) begin
			send_slot(i[0] ? 8'd0 : 8'd1, 0);
			send_slot(8'd255, 0);
		end

		// Default screen, with the receiver holding off while words pile up.
		sink_busy = 0;
		run_frames(60);
		sink_busy = 1;
		hold_req = 1;
		run_frames(200);

		// Widest screen, fastest flight, all-ones seed.
		wait_idle();
		set_screen(0, 4095, 0, 4095, 2000, 32'hffff_ffff);
		run_frames(250);

		// Inverted screen: every projected star falls out of bounds.
		wait_idle();
		set_screen(600, 10, 400, 5, 300, 32'd0);
		run_frames(150);

		// Stalled flight on a small window.
		wait_idle();
		set_screen(100, 227, 50, 177, 0, 32'd12345);
		run_frames(200);

		// Random settings; a run of frame words drives the budget to its ceiling.
		wait_idle();
		set_screen($urandom_range(0, 300), $urandom_range(400, 4095), $urandom_range(0, 300),
			$urandom_range(400, 4095), $urandom_range(300, 2000), $urandom());
		for (int i = 0; i < 130; i++) send_slot(8'd0, 0);
		run_frames(300);

		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pixels_due.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#12ms;
		$display("tb: failure");
		$finish;
	end

endmodule
